// File: rtl/mclr_pkg.sv
`default_nettype none
package mclr_pkg;

    localparam int CHANNELS_DEF = 64;
    localparam int CNT_W        = 7;
    localparam int CH_W         = 6;
    localparam int DELTA_W      = 16;
    localparam int VAL_W        = 32;
    localparam int TIN_W        = 31;
    localparam int PROD_W       = 50;
    localparam int DIV_NUM_W    = 49;
    localparam int DIV_DEN_W    = 31;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TK_RD,
        S_TK_CALC,
        S_TK_GO,
        S_TK_DIV,
        S_RD_WAIT,
        S_RD_GO,
        S_RD_DIV,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        t_action                   op;
        logic [CH_W-1:0]           channel;
        logic [DELTA_W-1:0]        delta;
        logic                      set_value;
        logic                      set_goal;
        logic signed [VAL_W-1:0]   value;
        logic signed [VAL_W-1:0]   goal;
        logic signed [VAL_W-1:0]   ticks;
    } t_cmd;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[PROD_W-1:VAL_W-1];
        all_zero = ~|v[PROD_W-1:VAL_W-1];
        if (all_one || all_zero) begin
            return v[VAL_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

    // remaining time minus elapsed, clamped at the signed minimum
    function automatic logic signed [VAL_W-1:0] time_step(input logic signed [VAL_W-1:0] t,
                                                          input logic [DELTA_W-1:0] d);
        logic signed [PROD_W-1:0] diff;
        diff = $signed({{(PROD_W-VAL_W){t[VAL_W-1]}}, t})
             - $signed({{(PROD_W-DELTA_W){1'b0}}, d});
        return sat32(diff);
    endfunction

endpackage
`default_nettype wire

// File: rtl/mclr_if.sv
`default_nettype none
interface mclr_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic [mclr_pkg::CH_W-1:0]             channel;
    logic [mclr_pkg::DELTA_W-1:0]          delta_ticks;
    logic signed [mclr_pkg::VAL_W-1:0]     first_value;
    logic [mclr_pkg::TIN_W-1:0]            first_time;
    logic                                  has_second;
    logic signed [mclr_pkg::VAL_W-1:0]     second_value;
    logic [mclr_pkg::TIN_W-1:0]            second_time;

    modport source (output valid, action, channel, delta_ticks, first_value, first_time,
                    has_second, second_value, second_time, input ready);
    modport sink   (input valid, action, channel, delta_ticks, first_value, first_time,
                    has_second, second_value, second_time, output ready);
endinterface

interface mclr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mclr_pkg::VAL_W-1:0]     current_value;
    logic signed [mclr_pkg::VAL_W-1:0]     velocity;
    logic signed [mclr_pkg::VAL_W-1:0]     goal_value;
    logic signed [mclr_pkg::VAL_W-1:0]     difference;
    logic signed [mclr_pkg::VAL_W-1:0]     time_left;

    modport source (output valid, current_value, velocity, goal_value, difference, time_left,
                    input ready);
    modport sink   (input valid, current_value, velocity, goal_value, difference, time_left,
                    output ready);
endinterface

interface mclr_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mclr_pkg::CNT_W-1:0]            active_channels;

    modport source (output valid, active_channels, input ready);
    modport sink   (input valid, active_channels, output ready);
endinterface
`default_nettype wire

// File: rtl/mclr_front.sv
`default_nettype none
module mclr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    mclr_in_if.sink             i_in,
    output mclr_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_pop
);
    import mclr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd            r_queue [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    t_cmd            cmd_in;
    logic            push;
    logic            pop;

    // decode the set rules up front so the back end only sees write masks
    always_comb begin
        cmd_in.op        = t_action'(i_in.action);
        cmd_in.channel   = i_in.channel;
        cmd_in.delta     = i_in.delta_ticks;
        cmd_in.set_value = (i_in.first_time == '0);
        cmd_in.set_goal  = (i_in.first_time != '0) || i_in.has_second;
        cmd_in.value     = i_in.first_value;
        if (i_in.first_time != '0) begin
            cmd_in.goal  = i_in.first_value;
            cmd_in.ticks = $signed({1'b0, i_in.first_time});
        end else begin
            cmd_in.goal  = i_in.second_value;
            cmd_in.ticks = $signed({1'b0, i_in.second_time});
        end
    end

    assign i_in.ready  = (r_count != (PW+1)'(QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/mclr_div.sv
`default_nettype none
module mclr_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [mclr_pkg::DIV_NUM_W-1:0]     i_num,
    input  wire logic [mclr_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                                    o_done,
    output logic [mclr_pkg::DIV_NUM_W-1:0]          o_quot
);
    import mclr_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_NUM_W-1:0]   r_num;
    logic [DIV_DEN_W-1:0]   r_den;
    logic [DIV_DEN_W-1:0]   r_rem;
    logic [DIV_DEN_W:0]     trial;
    logic                   fits;

    // restoring, one quotient bit per cycle; quotient shifts in behind the numerator
    assign trial  = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], fits};
            r_rem <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/mclr_back.sv
`default_nettype none
module mclr_back #(
    parameter int CHANNELS = mclr_pkg::CHANNELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mclr_pkg::t_cmd      i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    mclr_cfg_if.sink            i_cfg,
    mclr_out_if.source          o_out
);
    import mclr_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = $clog2(CHANNELS + 1);

    logic signed [VAL_W-1:0]  mem_val  [CHANNELS];
    logic signed [VAL_W-1:0]  mem_goal [CHANNELS];
    logic signed [VAL_W-1:0]  mem_time [CHANNELS];
    logic [CHANNELS-1:0]      r_valid;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_active;
    logic [NW-1:0]            r_idx;
    logic [NW-1:0]            live;
    logic [NW-1:0]            cfg_live;
    logic                     ok;
    logic [AW-1:0]            ch_addr;
    logic [AW-1:0]            rd_addr;

    logic signed [VAL_W-1:0]  r_q_val;
    logic signed [VAL_W-1:0]  r_q_goal;
    logic signed [VAL_W-1:0]  r_q_time;
    logic                     r_q_ok;
    logic signed [VAL_W-1:0]  mv;
    logic signed [VAL_W-1:0]  mg;
    logic signed [VAL_W-1:0]  mt;
    logic signed [VAL_W:0]    d33;
    logic signed [DELTA_W:0]  dl17;
    logic signed [PROD_W-1:0] prod;

    logic signed [VAL_W-1:0]  r_v;
    logic signed [VAL_W-1:0]  r_g;
    logic signed [VAL_W-1:0]  r_t;
    logic signed [VAL_W-1:0]  r_vel;
    logic signed [PROD_W-1:0] r_prod;
    logic [DELTA_W-1:0]       r_delta;

    logic                     we;
    logic                     we_val;
    logic                     we_goal;
    logic                     we_time;
    logic [AW-1:0]            wr_addr;
    logic signed [VAL_W-1:0]  wr_val;
    logic signed [VAL_W-1:0]  wr_goal;
    logic signed [VAL_W-1:0]  wr_time;
    logic                     advance;
    logic                     last;

    logic                     div_start;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic signed [PROD_W-1:0] quot_s;

    logic                     r_out_valid;
    logic                     out_load;

    assign live     = (int'(r_active) < CHANNELS) ? NW'(r_active) : NW'(CHANNELS);
    assign cfg_live = (int'(i_cfg.active_channels) < CHANNELS)
                    ? NW'(i_cfg.active_channels) : NW'(CHANNELS);
    assign ok       = (int'(i_cmd.channel) < int'(live));
    assign ch_addr  = AW'(i_cmd.channel);
    assign last     = ((r_idx + 1'b1) == live);
    assign i_cfg.ready = 1'b1;

    // entries without a valid bit read as zero
    assign mv   = r_q_ok ? r_q_val  : '0;
    assign mg   = r_q_ok ? r_q_goal : '0;
    assign mt   = r_q_ok ? r_q_time : '0;
    assign d33  = {mg[VAL_W-1], mg} - {mv[VAL_W-1], mv};
    assign dl17 = $signed({1'b0, r_delta});
    assign prod = d33 * dl17;

    assign div_num = r_prod[PROD_W-1] ? DIV_NUM_W'(-r_prod) : DIV_NUM_W'(r_prod);
    assign quot_s  = r_prod[PROD_W-1] ? -$signed(PROD_W'(div_quot))
                                      : $signed(PROD_W'(div_quot));

    mclr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_t[DIV_DEN_W-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        rd_addr   = r_idx[AW-1:0];
        we        = 1'b0;
        we_val    = 1'b0;
        we_goal   = 1'b0;
        we_time   = 1'b0;
        wr_addr   = r_idx[AW-1:0];
        wr_val    = mg;
        wr_goal   = mg;
        wr_time   = time_step(mt, r_delta);
        advance   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = ch_addr;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        ACT_TICK: begin
                            if (live != '0) begin
                                n_state = S_TK_RD;
                            end
                        end
                        ACT_SET: begin
                            if (ok) begin
                                we      = 1'b1;
                                wr_addr = ch_addr;
                                we_val  = i_cmd.set_value || !r_valid[ch_addr];
                                we_goal = i_cmd.set_goal || !r_valid[ch_addr];
                                we_time = we_goal;
                                wr_val  = i_cmd.set_value ? i_cmd.value : '0;
                                wr_goal = i_cmd.set_goal ? i_cmd.goal : '0;
                                wr_time = i_cmd.set_goal ? i_cmd.ticks : '0;
                            end
                        end
                        ACT_READ: begin
                            n_state = ok ? S_RD_WAIT : S_RD_OUT;
                        end
                        ACT_CLEAR: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TK_RD: begin
                n_state = S_TK_CALC;
            end
            S_TK_CALC: begin
                if (mt > 0) begin
                    n_state = S_TK_GO;
                end else begin
                    we      = 1'b1;
                    we_val  = 1'b1;
                    we_goal = 1'b1;
                    we_time = 1'b1;
                    advance = 1'b1;
                end
            end
            S_TK_GO: begin
                div_start = 1'b1;
                n_state   = S_TK_DIV;
            end
            S_TK_DIV: begin
                wr_val  = sat32($signed(PROD_W'(r_v)) + quot_s);
                wr_goal = r_g;
                wr_time = time_step(r_t, r_delta);
                if (div_done) begin
                    we      = 1'b1;
                    we_val  = 1'b1;
                    we_goal = 1'b1;
                    we_time = 1'b1;
                    advance = 1'b1;
                end
            end
            S_RD_WAIT: begin
                n_state = (mt > 0) ? S_RD_GO : S_RD_OUT;
            end
            S_RD_GO: begin
                div_start = 1'b1;
                n_state   = S_RD_DIV;
            end
            S_RD_DIV: begin
                if (div_done) begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (advance) begin
            n_state = last ? S_IDLE : S_TK_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && we_val) begin
            mem_val[wr_addr] <= wr_val;
        end
        if (we && we_goal) begin
            mem_goal[wr_addr] <= wr_goal;
        end
        if (we && we_time) begin
            mem_time[wr_addr] <= wr_time;
        end
        r_q_val  <= mem_val[rd_addr];
        r_q_goal <= mem_goal[rd_addr];
        r_q_time <= mem_time[rd_addr];
        r_q_ok   <= r_valid[rd_addr];
    end

    // working registers of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_delta <= i_cmd.delta;
                r_v     <= '0;
                r_g     <= '0;
                r_t     <= '0;
                r_vel   <= '0;
            end
            S_TK_CALC: begin
                r_v    <= mv;
                r_g    <= mg;
                r_t    <= mt;
                r_prod <= prod;
            end
            S_RD_WAIT: begin
                r_v    <= mv;
                r_g    <= mg;
                r_t    <= mt;
                r_prod <= PROD_W'(d33);
                r_vel  <= '0;
            end
            S_RD_DIV: begin
                if (div_done) begin
                    r_vel <= sat32(quot_s);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            o_out.current_value <= r_v;
            o_out.velocity      <= r_vel;
            o_out.goal_value    <= r_g;
            o_out.difference    <= sat32($signed(PROD_W'(r_g)) - $signed(PROD_W'(r_v)));
            o_out.time_left     <= r_t;
        end
    end

    assign o_out.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (advance) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_active <= i_cfg.active_channels;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (i >= int'(cfg_live)) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end else if (r_state == S_IDLE && i_cmd_valid && ok) begin
                if (i_cmd.op == ACT_SET) begin
                    r_valid[ch_addr] <= 1'b1;
                end else if (i_cmd.op == ACT_CLEAR) begin
                    r_valid[ch_addr] <= 1'b0;
                end
            end else if (we) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/multi_channel_linear_ramp_core.sv
// set and clear: applied from the command queue once the sequencer is idle, no result
// read: result goes through the divider when time is positive, skips it otherwise
// tick: visits every active channel in turn, waiting on the one-bit-per-cycle divider
//   for each channel with positive time; the divider is shared by all channels
// a two-entry command queue takes new items while the sequencer works
// synchronous active-low reset zeroes the register and all channel valid bits at once
`default_nettype none
module multi_channel_linear_ramp_core #(
    parameter int CHANNELS = mclr_pkg::CHANNELS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mclr_in_if.sink     i_in,
    mclr_cfg_if.sink    i_cfg,
    mclr_out_if.source  o_out
);
    import mclr_pkg::*;

    t_cmd   cmd;
    logic   cmd_valid;
    logic   cmd_pop;

    mclr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    mclr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: rtl/mclr_check.sv
`default_nettype none
module mclr_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic signed [mclr_pkg::VAL_W-1:0] i_current_value,
    input  wire logic signed [mclr_pkg::VAL_W-1:0] i_velocity,
    input  wire logic signed [mclr_pkg::VAL_W-1:0] i_goal_value,
    input  wire logic signed [mclr_pkg::VAL_W-1:0] i_difference,
    input  wire logic signed [mclr_pkg::VAL_W-1:0] i_time_left
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_velocity != '0 |-> i_time_left > 0)
        else $error("velocity without remaining time");

    a_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_goal_value == i_current_value |-> i_difference == '0)
        else $error("difference nonzero at goal");

endmodule

bind multi_channel_linear_ramp_core mclr_check u_mclr_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_current_value (o_out.current_value),
    .i_velocity      (o_out.velocity),
    .i_goal_value    (o_out.goal_value),
    .i_difference    (o_out.difference),
    .i_time_left     (o_out.time_left)
);
`default_nettype wire

// File: dv/multi_channel_linear_ramp_core_tb.sv
`default_nettype none
module multi_channel_linear_ramp_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mclr_pkg::*;

    localparam int NCH = 64;

    typedef struct {
        t_action act;
        logic [5:0] ch;
        logic [15:0] dt;
        logic signed [31:0] v0;
        logic [30:0] t0;
        logic two;
        logic signed [31:0] v1;
        logic [30:0] t1;
        bit known;
        logic signed [31:0] e_val;
        logic signed [31:0] e_vel;
        logic signed [31:0] e_goal;
        logic signed [31:0] e_diff;
        logic signed [31:0] e_time;
    } ramp_op_t;

    typedef struct {
        logic signed [31:0] val;
        logic signed [31:0] vel;
        logic signed [31:0] goal;
        logic signed [31:0] diff;
        logic signed [31:0] tl;
    } ramp_rd_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    mclr_in_if  in_ch();
    mclr_cfg_if cfg_ch();
    mclr_out_if out_ch();

    multi_channel_linear_ramp_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    logic signed [31:0] m_val [NCH];
    logic signed [31:0] m_goal[NCH];
    logic signed [31:0] m_time[NCH];
    int unsigned m_count;

    ramp_rd_t read_queue[$];
    int unsigned n_errors = 0;
    int unsigned n_reads = 0, n_ticks = 0, n_sets = 0, n_clears = 0, n_cfg = 0;
    longint unsigned cycles = 0;
    int idle_pct = 27;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    task automatic predict_count(input logic [6:0] n);
        m_count = (n > NCH) ? NCH : n;
        for (int i = m_count; i < NCH; i++) begin
            m_val[i] = 0; m_goal[i] = 0; m_time[i] = 0;
        end
    endtask

    task automatic predict_op(input ramp_op_t op);
        logic signed [63:0] d, t, stp;
        ramp_rd_t r;
        bit ok;
        ok = op.ch < m_count;
        case (op.act)
            ACT_TICK: begin
                for (int i = 0; i < m_count; i++) begin
                    t = m_time[i];
                    if (t > 0) begin
                        d = 64'(m_goal[i]) - 64'(m_val[i]);
                        stp = (d * $signed({48'd0, op.dt})) / t;
                        m_val[i] = clamp32(64'(m_val[i]) + stp);
                    end else begin
                        m_val[i] = m_goal[i];
                    end
                    m_time[i] = clamp32(t - $signed({48'd0, op.dt}));
                end
            end
            ACT_SET: if (ok) begin
                if (op.t0 == 0) begin
                    m_val[op.ch] = op.v0;
                    if (op.two) begin
                        m_goal[op.ch] = op.v1;
                        m_time[op.ch] = {1'b0, op.t1};
                    end
                end else begin
                    m_goal[op.ch] = op.v0;
                    m_time[op.ch] = {1'b0, op.t0};
                end
            end
            ACT_CLEAR: if (ok) begin
                m_val[op.ch] = 0; m_goal[op.ch] = 0; m_time[op.ch] = 0;
            end
            default: begin
                r = '{0, 0, 0, 0, 0};
                if (ok) begin
                    d = 64'(m_goal[op.ch]) - 64'(m_val[op.ch]);
                    t = m_time[op.ch];
                    r.val = m_val[op.ch];
                    r.vel = (t > 0) ? clamp32(d / t) : 0;
                    r.goal = m_goal[op.ch];
                    r.diff = clamp32(d);
                    r.tl = m_time[op.ch];
                end
                if (op.known && (r.val !== op.e_val || r.vel !== op.e_vel ||
                                 r.goal !== op.e_goal || r.diff !== op.e_diff ||
                                 r.tl !== op.e_time))
                    report_mismatch("directed read value differs from typed expectation");
                read_queue.insert(read_queue.size(), r);
            end
        endcase
    endtask

    // output side: random stall, compare each read item
    initial begin
        ramp_rd_t e;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (read_queue.size() == 0) begin
                    report_mismatch("read item with nothing expected");
                end else begin
                    e = read_queue.pop_front();
                    if (out_ch.current_value !== e.val)
                        report_mismatch($sformatf("current_value %h exp %h",
                            out_ch.current_value, e.val));
                    if (out_ch.velocity !== e.vel)
                        report_mismatch($sformatf("velocity %h exp %h", out_ch.velocity, e.vel));
                    if (out_ch.goal_value !== e.goal)
                        report_mismatch($sformatf("goal_value %h exp %h",
                            out_ch.goal_value, e.goal));
                    if (out_ch.difference !== e.diff)
                        report_mismatch($sformatf("difference %h exp %h",
                            out_ch.difference, e.diff));
                    if (out_ch.time_left !== e.tl)
                        report_mismatch($sformatf("time_left %h exp %h", out_ch.time_left, e.tl));
                end
            end
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 64'd20000000) begin
                $display("timeout after %0d cycles", cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // valid stays high into the next item unless an idle cycle comes first
    task automatic send_op(input ramp_op_t op);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= op.act;
        in_ch.channel <= op.ch;
        in_ch.delta_ticks <= op.dt;
        in_ch.first_value <= op.v0;
        in_ch.first_time <= op.t0;
        in_ch.has_second <= op.two;
        in_ch.second_value <= op.v1;
        in_ch.second_time <= op.t1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_op(op);
        case (op.act)
            ACT_TICK: n_ticks++;
            ACT_SET: n_sets++;
            ACT_READ: n_reads++;
            default: n_clears++;
        endcase
        @(negedge i_clk);
    endtask

    // drain, then let ticks with no result finish before touching the register
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (read_queue.size() != 0) @(negedge i_clk);
        repeat (4 * 64 * 60) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] n);
        wait_quiet();
        cfg_ch.valid <= 1'b1;
        cfg_ch.active_channels <= n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        predict_count(n);
        n_cfg++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic ramp_op_t mk(t_action a, logic [5:0] c, logic [15:0] dt,
                                    logic signed [31:0] v0, logic [30:0] t0, logic two,
                                    logic signed [31:0] v1, logic [30:0] t1);
        ramp_op_t o;
        o = '{a, c, dt, v0, t0, two, v1, t1, 1'b0, 0, 0, 0, 0, 0};
        return o;
    endfunction

    function automatic ramp_op_t mk_rd(logic [5:0] c, logic signed [31:0] a,
                                       logic signed [31:0] b, logic signed [31:0] g,
                                       logic signed [31:0] d, logic signed [31:0] t);
        ramp_op_t o;
        o = mk(ACT_READ, c, 0, 0, 0, 0, 0, 0);
        o.known = 1'b1;
        o.e_val = a; o.e_vel = b; o.e_goal = g; o.e_diff = d; o.e_time = t;
        return o;
    endfunction

    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(255))) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_time();
        case ($urandom_range(5))
            0: return 31'h7fffffff;
            1: return '0;
            2: return 31'($urandom_range(8, 1));
            3: return 31'($urandom);
            default: return 31'($urandom_range(300, 1));
        endcase
    endfunction

    function automatic ramp_op_t pick_op(int unsigned n);
        ramp_op_t o;
        int unsigned r;
        logic [5:0] c;
        r = $urandom_range(99);
        // mostly channels in use, sometimes beyond
        c = ($urandom_range(9) == 0 || n == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
        o = mk(ACT_READ, c, 0, pick_val(), pick_time(), 1'($urandom), pick_val(), pick_time());
        o.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        if ($urandom_range(3) == 0) o.t0 = 0;
        if (r < 20) o.act = ACT_TICK;
        else if (r < 55) o.act = ACT_SET;
        else if (r < 62) o.act = ACT_CLEAR;
        return o;
    endfunction

    ramp_op_t dir_tbl[$];

    initial begin
        in_ch.valid = 1'b0; in_ch.action = '0; in_ch.channel = '0; in_ch.delta_ticks = '0;
        in_ch.first_value = '0; in_ch.first_time = '0; in_ch.has_second = 1'b0;
        in_ch.second_value = '0; in_ch.second_time = '0;
        cfg_ch.valid = 1'b0; cfg_ch.active_channels = '0;
        predict_count(0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // channels all idle after reset, count zero
        dir_tbl = '{
            mk_rd(0, 0, 0, 0, 0, 0),
            mk(ACT_SET, 5, 0, 32'sh10000, 0, 1, 32'sh20000, 4),
            mk_rd(5, 0, 0, 0, 0, 0)
        };
        foreach (dir_tbl[i]) send_op(dir_tbl[i]);

        write_count(7'd100);
        dir_tbl = '{
            mk_rd(63, 0, 0, 0, 0, 0),
            mk(ACT_SET, 0, 0, 32'sh7fffffff, 0, 1, 32'sh80000000, 31'h7fffffff),
            mk_rd(0, 32'sh7fffffff, -32'sd2, 32'sh80000000, 32'sh80000000, 32'h7fffffff),
            mk(ACT_SET, 1, 0, -32'sh10000, 0, 0, 0, 0),
            mk_rd(1, -32'sh10000, 0, 0, 32'sh10000, 0),
            mk(ACT_SET, 2, 0, 32'sh30000, 3, 0, 0, 0),
            mk(ACT_SET, 3, 0, 32'sh80000000, 0, 1, 32'sh7fffffff, 2),
            mk(ACT_TICK, 0, 1, 0, 0, 0, 0, 0),
            mk(ACT_READ, 2, 0, 0, 0, 0, 0, 0),
            mk(ACT_TICK, 0, 16'hffff, 0, 0, 0, 0, 0),
            mk(ACT_READ, 3, 0, 0, 0, 0, 0, 0),
            mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0),
            mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 0),
            mk(ACT_CLEAR, 2, 0, 0, 0, 0, 0, 0),
            mk_rd(2, 0, 0, 0, 0, 0),
            mk(ACT_READ, 1, 0, 0, 0, 0, 0, 0)
        };
        foreach (dir_tbl[i]) send_op(dir_tbl[i]);

        // drop to a few channels: upper ones must read zero and ignore set and clear
        write_count(7'd2);
        dir_tbl = '{
            mk_rd(3, 0, 0, 0, 0, 0),
            mk(ACT_SET, 4, 0, 32'sh5, 9, 0, 0, 0),
            mk(ACT_CLEAR, 40, 0, 0, 0, 0, 0, 0),
            mk_rd(4, 0, 0, 0, 0, 0),
            mk(ACT_READ, 1, 0, 0, 0, 0, 0, 0)
        };
        foreach (dir_tbl[i]) send_op(dir_tbl[i]);

        for (int ph = 0; ph < 6; ph++) begin
            logic [6:0] cnt;
            case (ph)
                0: cnt = 7'd4;
                1: cnt = 7'd1;
                2: cnt = 7'd64;
                3: cnt = 7'd127;
                4: cnt = 7'd0;
                default: cnt = 7'($urandom_range(12, 2));
            endcase
            write_count(cnt);
            idle_pct = (ph == 2) ? 0 : 27;
            for (int k = 0; k < 225; k++) begin
                if (ph == 1 && k == 100) begin
                    in_ch.valid <= 1'b0;
                    while (read_queue.size() != 0) @(negedge i_clk);
                end
                send_op(pick_op(m_count));
            end
        end
        idle_pct = 27;

        in_ch.valid <= 1'b0;
        while (read_queue.size() != 0) @(negedge i_clk);
        repeat (64 * 60) @(negedge i_clk);
        $display("covered %0d ticks, %0d sets, %0d clears, %0d reads over %0d count writes",
                 n_ticks, n_sets, n_clears, n_reads, n_cfg);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
